// File: rtl/amdf_pkg.sv
// Shared types, state codes and sizes for the AMDF pitch tracker.
// Used by amdf_ctrl, amdf_dp and the top level; depends on nothing.
package amdf_pkg;

	localparam int DEPTH      = 2048;
	localparam int ADDR_W     = 11;
	localparam int SAMPLE_W   = 16;
	localparam int PER_W      = 11;
	localparam int MAX_LAG    = 1024;
	localparam int SUM_W      = 27;
	localparam int SQ_W       = 41;
	localparam int DIV_STEPS  = 41;
	localparam int SQRT_STEPS = 21;
	localparam int CNT_W      = 6;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLR  = 4'd1;
	localparam logic [3:0] ST_AMDF = 4'd2;
	localparam logic [3:0] ST_MOVE = 4'd3;
	localparam logic [3:0] ST_MED  = 4'd4;
	localparam logic [3:0] ST_RMS  = 4'd5;
	localparam logic [3:0] ST_DIVR = 4'd6;
	localparam logic [3:0] ST_SQRT = 4'd7;
	localparam logic [3:0] ST_DIVF = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	localparam logic [1:0] REG_RATE = 2'd0;
	localparam logic [1:0] REG_MIN  = 2'd1;
	localparam logic [1:0] REG_MAX  = 2'd2;

	typedef struct packed {
		logic [3:0] op;
		logic       start;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic bad;
		logic frame_end;
		logic per_zero;
		logic restart;
		logic out_free;
	} stat_t;

	function automatic logic [PER_W-1:0] median3(input logic [PER_W-1:0] a,
		input logic [PER_W-1:0] b, input logic [PER_W-1:0] c);
		logic [PER_W-1:0] lo, hi, m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m  = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction

endpackage

// File: rtl/amdf_ctrl.sv
// Sequencer: clears after reset or period write; steps each item via
// search/move/median (frames), RMS, divide, sqrt. Uses amdf_pkg.
module amdf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  amdf_pkg::stat_t stat,
	input  logic           s_tvalid,
	output logic           s_tready,
	output amdf_pkg::cmd_t cmd
);

	logic [3:0] state_q, nxt;
	logic       start_q;

	assign s_tready  = (state_q == amdf_pkg::ST_IDLE);
	assign cmd.op    = state_q;
	assign cmd.start = start_q;

	always_comb begin
		nxt = state_q;
		if (stat.restart) begin
			nxt = amdf_pkg::ST_CLR;
		end else begin
			unique case (state_q)
				amdf_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						if (stat.bad) nxt = amdf_pkg::ST_OUT;
						else if (stat.frame_end) nxt = amdf_pkg::ST_AMDF;
						else nxt = amdf_pkg::ST_RMS;
					end
				end
				amdf_pkg::ST_CLR:  if (stat.done) nxt = amdf_pkg::ST_IDLE;
				amdf_pkg::ST_AMDF: if (stat.done) nxt = amdf_pkg::ST_MOVE;
				amdf_pkg::ST_MOVE: if (stat.done) nxt = amdf_pkg::ST_MED;
				amdf_pkg::ST_MED:  nxt = amdf_pkg::ST_RMS;
				amdf_pkg::ST_RMS: begin
					if (stat.per_zero) nxt = amdf_pkg::ST_OUT;
					else if (stat.done) nxt = amdf_pkg::ST_DIVR;
				end
				amdf_pkg::ST_DIVR: if (stat.done) nxt = amdf_pkg::ST_SQRT;
				amdf_pkg::ST_SQRT: if (stat.done) nxt = amdf_pkg::ST_DIVF;
				amdf_pkg::ST_DIVF: if (stat.done) nxt = amdf_pkg::ST_OUT;
				amdf_pkg::ST_OUT:  if (stat.out_free) nxt = amdf_pkg::ST_IDLE;
				default: nxt = amdf_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amdf_pkg::ST_CLR;
			start_q <= 1'b1;
		end else begin
			state_q <= nxt;
			start_q <= (nxt != state_q) || stat.restart;
		end
	end

endmodule

// File: rtl/amdf_dp.sv
// Datapath of the pitch tracker: sample memory, AMDF accumulator, median,
// RMS accumulator, shared divider, square root and output register. Uses amdf_pkg.
module amdf_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  amdf_pkg::cmd_t  cmd,
	input  logic            take,
	input  logic [15:0]     sample,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [17:0]     cfg_data,
	input  logic            out_ready,
	output amdf_pkg::stat_t stat,
	output logic            out_valid,
	output logic [55:0]     out_data,
	output logic            out_last,
	output logic            out_user
);

	localparam int AW = amdf_pkg::ADDR_W;
	localparam int PW = amdf_pkg::PER_W;

	logic [17:0] rate_q;
	logic [9:0]  minp_q;
	logic [PW-1:0] maxp_q;
	logic [11:0] wp_q;
	logic [PW-1:0] cur_q;
	logic [PW-1:0] hist_q [3];
	logic [PW-1:0] res_q [3];
	logic [1:0]  slot_q;

	logic signed [15:0] mem_q [amdf_pkg::DEPTH];
	logic signed [15:0] rd0_q, rd1_q;
	logic [AW-1:0] ra0, ra1, wa;
	logic signed [15:0] wd;
	logic we;

	logic [AW-1:0] ca_q, i_q, lag_q, lag_s1, wa_s1, best_q;
	logic [11:0]   n_q;
	logic          iss_q, v_s1, fin_s1, last_s1, v_s2, fin_s2;
	logic [amdf_pkg::SUM_W-1:0] acc_q, bsum_q, sum;
	logic [31:0]   sq_s2;
	logic [amdf_pkg::SQ_W-1:0] sqacc_q, num_q;
	logic [PW-1:0] peri_q, dv_q, rem_q;
	logic [41:0]   sv_q, sres_q, sbit_q, strial;
	logic [amdf_pkg::CNT_W-1:0] cnt_q;
	logic          run_q, frame_q, err_q;

	logic [3:0]  op;
	logic        st;
	logic [11:0] size, wp_eff, peri12, sp, room, nn;
	logic [12:0] sp13;
	logic        bad, fe, restart, last_i, load, done;
	logic [9:0]  nmin;
	logic [PW-1:0] nmax, med;
	logic [11:0] nsum;
	logic [16:0] d, ad;
	logic [11:0] t;
	logic        ge;
	logic [1:0]  oth;
	logic [PW-1:0] h0, h1, h2;

	assign op   = cmd.op;
	assign st   = cmd.start;
	assign size = {maxp_q, 1'b0};
	assign bad  = (maxp_q <= {1'b0, minp_q}) || (maxp_q > PW'(amdf_pkg::MAX_LAG));
	assign wp_eff = (wp_q >= size) ? 12'd0 : wp_q;
	assign fe   = ((wp_eff + 12'd1) == size);
	assign restart = cfg_we && ((cfg_index == amdf_pkg::REG_MIN) ||
		(cfg_index == amdf_pkg::REG_MAX));
	assign nmin = (cfg_index == amdf_pkg::REG_MIN) ? cfg_data[9:0] : minp_q;
	assign nmax = (cfg_index == amdf_pkg::REG_MAX) ? cfg_data[PW-1:0] : maxp_q;
	assign nsum = {2'b0, nmin} + {1'b0, nmax};
	assign last_i = (i_q == maxp_q - PW'(1));

	// RMS window: clamp the period to the buffer, positions past its end count as zero
	assign peri12 = ({1'b0, cur_q} > size) ? size : {1'b0, cur_q};
	assign sp13   = {1'b0, wp_q} + {1'b0, size} - {1'b0, peri12};
	assign sp     = (sp13 >= {1'b0, size}) ? 12'(sp13 - {1'b0, size}) : sp13[11:0];
	assign room   = size - sp;
	assign nn     = (peri12 < room) ? peri12 : room;

	assign d   = {rd1_q[15], rd1_q} - {rd0_q[15], rd0_q};
	assign ad  = d[16] ? (~d + 17'd1) : d;
	assign sum = acc_q + amdf_pkg::SUM_W'(ad[15:0]);

	assign t  = {rem_q, num_q[amdf_pkg::SQ_W-1]};
	assign ge = (t >= {1'b0, dv_q});
	assign strial = sres_q + sbit_q;

	assign h0  = (slot_q == 2'd0) ? best_q : hist_q[0];
	assign h1  = (slot_q == 2'd1) ? best_q : hist_q[1];
	assign h2  = (slot_q == 2'd2) ? best_q : hist_q[2];
	assign med = amdf_pkg::median3(h0, h1, h2);
	assign oth = (slot_q == 2'd0) ? 2'd2 : ((slot_q == 2'd1) ? 2'd0 : 2'd1);

	assign ra0 = (op == amdf_pkg::ST_MOVE) ? (maxp_q + i_q) : i_q;
	assign ra1 = i_q + lag_q;

	always_comb begin
		we = 1'b0;
		wa = wa_s1;
		wd = rd0_q;
		if (take && !bad) begin
			we = 1'b1;
			wa = wp_eff[AW-1:0];
			wd = sample;
		end else if (op == amdf_pkg::ST_CLR && !st) begin
			we = 1'b1;
			wa = ca_q;
			wd = '0;
		end else if (op == amdf_pkg::ST_MOVE && v_s1) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd0_q <= mem_q[ra0];
		rd1_q <= mem_q[ra1];
	end

	always_comb begin
		unique case (op)
			amdf_pkg::ST_CLR:  done = !st && (ca_q == AW'(amdf_pkg::DEPTH - 1));
			amdf_pkg::ST_AMDF,
			amdf_pkg::ST_MOVE: done = v_s1 && fin_s1;
			amdf_pkg::ST_RMS:  done = v_s2 && fin_s2;
			amdf_pkg::ST_DIVR,
			amdf_pkg::ST_SQRT,
			amdf_pkg::ST_DIVF: done = !st && run_q && (cnt_q == '0);
			default:           done = 1'b0;
		endcase
	end
	assign stat.done      = done;
	assign stat.bad       = bad;
	assign stat.frame_end = fe;
	assign stat.per_zero  = (cur_q == '0);
	assign stat.restart   = restart;
	assign stat.out_free  = !out_valid || out_ready;

	assign load = (op == amdf_pkg::ST_OUT) && (!out_valid || out_ready);

	// configuration and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 18'd48000;
			minp_q <= 10'd48;
			maxp_q <= PW'(480);
			wp_q   <= '0;
			cur_q  <= PW'(264);
			for (int k = 0; k < 3; k++) begin
				hist_q[k] <= '0;
				res_q[k]  <= '0;
			end
			slot_q  <= '0;
			frame_q <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == amdf_pkg::REG_RATE) rate_q <= cfg_data;
			if (restart) begin
				minp_q <= nmin;
				maxp_q <= nmax;
				wp_q   <= '0;
				cur_q  <= nsum[11:1];
				for (int k = 0; k < 3; k++) begin
					hist_q[k] <= '0;
					res_q[k]  <= '0;
				end
				slot_q <= '0;
			end else if (take) begin
				if (!bad) wp_q <= wp_eff + 12'd1;
				frame_q <= !bad && fe;
				err_q   <= bad;
			end else if (op == amdf_pkg::ST_MED) begin
				hist_q[slot_q] <= best_q;
				res_q[slot_q]  <= med;
				cur_q  <= res_q[oth];
				slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
				wp_q   <= {1'b0, maxp_q};
			end
		end
	end

	// address sequencing and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ca_q  <= '0;
			iss_q <= 1'b0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			run_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (op == amdf_pkg::ST_CLR) ca_q <= st ? '0 : ca_q + AW'(1);
			v_s1 <= iss_q && !st;
			v_s2 <= v_s1 && !st;
			if (st) begin
				iss_q <= (op == amdf_pkg::ST_AMDF) || (op == amdf_pkg::ST_MOVE) ||
					((op == amdf_pkg::ST_RMS) && (cur_q != '0));
				run_q <= (op == amdf_pkg::ST_DIVR) || (op == amdf_pkg::ST_SQRT) ||
					(op == amdf_pkg::ST_DIVF);
			end else begin
				if (iss_q) begin
					if (op == amdf_pkg::ST_AMDF) begin
						if (last_i && lag_q == maxp_q) iss_q <= 1'b0;
					end else if (op == amdf_pkg::ST_MOVE) begin
						if (last_i) iss_q <= 1'b0;
					end else if (n_q == 12'd1) begin
						iss_q <= 1'b0;
					end
				end
				if (run_q && cnt_q == '0) run_q <= 1'b0;
			end
			if (load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st) begin
			i_q   <= (op == amdf_pkg::ST_RMS) ? sp[AW-1:0] : '0;
			lag_q <= {1'b0, minp_q};
			n_q   <= nn;
			if (op == amdf_pkg::ST_RMS) peri_q <= peri12[PW-1:0];
		end else if (iss_q) begin
			if (op == amdf_pkg::ST_AMDF && last_i) begin
				i_q   <= '0;
				lag_q <= lag_q + AW'(1);
			end else begin
				i_q <= i_q + AW'(1);
			end
			n_q <= n_q - 12'd1;
		end
		wa_s1   <= i_q;
		lag_s1  <= lag_q;
		last_s1 <= last_i;
		unique case (op)
			amdf_pkg::ST_AMDF: fin_s1 <= last_i && (lag_q == maxp_q);
			amdf_pkg::ST_MOVE: fin_s1 <= last_i;
			default:           fin_s1 <= (n_q == 12'd1);
		endcase
		fin_s2 <= fin_s1;
		sq_s2  <= 32'(rd0_q * rd0_q);

		// AMDF sum per lag; strict compare keeps the earliest lag on ties
		if (st && op == amdf_pkg::ST_AMDF) begin
			acc_q <= '0;
		end else if (op == amdf_pkg::ST_AMDF && v_s1) begin
			if (last_s1) begin
				acc_q <= '0;
				if (lag_s1 == {1'b0, minp_q} || sum < bsum_q) begin
					best_q <= lag_s1;
					bsum_q <= sum;
				end
			end else begin
				acc_q <= sum;
			end
		end

		if (st && op == amdf_pkg::ST_RMS) sqacc_q <= '0;
		else if (op == amdf_pkg::ST_RMS && v_s2)
			sqacc_q <= sqacc_q + amdf_pkg::SQ_W'(sq_s2);

		// shared restoring divider and digit-by-digit square root
		if (st && op == amdf_pkg::ST_DIVR) begin
			num_q <= sqacc_q;
			rem_q <= '0;
			dv_q  <= peri_q;
			cnt_q <= amdf_pkg::CNT_W'(amdf_pkg::DIV_STEPS - 1);
		end else if (st && op == amdf_pkg::ST_DIVF) begin
			num_q <= amdf_pkg::SQ_W'({rate_q, 4'b0});
			rem_q <= '0;
			dv_q  <= cur_q;
			cnt_q <= amdf_pkg::CNT_W'(amdf_pkg::DIV_STEPS - 1);
		end else if (st && op == amdf_pkg::ST_SQRT) begin
			sv_q   <= 42'(num_q);
			sres_q <= '0;
			sbit_q <= 42'd1 << 40;
			cnt_q  <= amdf_pkg::CNT_W'(amdf_pkg::SQRT_STEPS - 1);
		end else if (run_q) begin
			cnt_q <= cnt_q - amdf_pkg::CNT_W'(1);
			if (op == amdf_pkg::ST_SQRT) begin
				if (sv_q >= strial) begin
					sv_q   <= sv_q - strial;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end else begin
				rem_q <= ge ? PW'(t - {1'b0, dv_q}) : t[PW-1:0];
				num_q <= {num_q[amdf_pkg::SQ_W-2:0], ge};
			end
		end

		if (load) begin
			if (err_q || cur_q == '0) out_data <= {45'd0, err_q ? PW'(0) : cur_q};
			else out_data <= {7'd0, sres_q[15:0], num_q[21:0], cur_q};
			out_last <= frame_q && !err_q;
			out_user <= err_q;
		end
	end

endmodule

// File: rtl/amdf_pitch_tracker.sv
// Top level of the AMDF pitch tracker: stream ports, config port, controller
// and datapath. Depends on amdf_pkg, amdf_ctrl and amdf_dp.
// An ordinary sample runs an RMS read of the last period samples, a 41-step
// divide, a 21-step root and a 41-step divide; a frame sample adds, before
// these, the lag search and buffer move, all through the one sample memory.
// Throughput: one item at a time. After reset and after a period register
// write the memory is swept to zero while s_tready stays low.
module amdf_pitch_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [10:0] period, [32:11] frequency_sixteenths, [48:33] rms_level
	output logic        m_tlast,   // frame_done
	output logic        m_tuser,   // [0] config_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_data
);

	amdf_pkg::cmd_t  cmd;
	amdf_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	amdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	amdf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.take      (s_tvalid && s_tready),
		.sample    (s_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.out_user  (m_tuser)
	);

endmodule

// File: rtl/amdf_checker.sv
// Port-level checks of the pitch tracker, bound to the top level.
// Depends only on the ports of amdf_pitch_tracker.
module amdf_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result item changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == 56'd0) && !m_tlast)
		else $error("config error item carries data");

	a_no_period: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[10:0] == 11'd0) |-> (m_tdata[48:11] == 38'd0))
		else $error("frequency or level without a period");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[55:49] == 7'd0))
		else $error("pad bits set");

endmodule

bind amdf_pitch_tracker amdf_port_checks u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
